// ===== design/lrw_pkg.sv =====
// Shared types and constants for the lollipop random-walk cover block.
// Holds the transaction payload structs, register indexes and sizing constants.
// No dependencies.
package lrw_pkg;

  // Field widths of the transactions.
  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int STEP_W  = 40;

  // Default graph capacity for the top-level parameter.
  localparam int MAX_NODES_DEF = 1024;

  // Visited-map entries hold the walk epoch that last marked them.
  // Epoch zero never names a live walk, so a cleared entry reads as unvisited.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

  // Saturation value of the step counter.
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  // Depth of the result queue.
  localparam int OUTQ_DEPTH = 3;

  // Operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Direction codes for path moves.
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // Configuration register indexes and reset values.
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_CLIQUE_SIZE = 1'b1;
  localparam int   CFG_AW          = 3;
  localparam int   CFG_DW          = 32;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST  = COUNT_W'(100);
  localparam logic [NODE_W-1:0]  CLIQUE_SIZE_RST = NODE_W'(66);

  // Input transaction.
  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] candidate_node;
    logic              direction;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic               accepted;
    logic [NODE_W-1:0]  node;
    logic [COUNT_W-1:0] visited_count;
    logic [STEP_W-1:0]  step_count;
    logic               covered;
  } out_item_t;

  // Effective graph shape after clamping the registers.
  typedef struct packed {
    logic [COUNT_W-1:0] nodes;
    logic [NODE_W-1:0]  clique;
  } graph_t;

endpackage

// ===== design/lrw_cfg.sv =====
// Configuration registers of the lollipop random-walk cover block.
// APB-style write/read port and clamping to the effective graph shape.
// Depends on lrw_pkg.
module lrw_cfg import lrw_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output graph_t            graph
);

  // Largest node count the 11-bit register and the map can both express.
  localparam int MAXC = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
  localparam logic [COUNT_W-1:0] NODES_HI = COUNT_W'(MAXC);
  localparam logic [COUNT_W-1:0] NODES_LO = COUNT_W'(2);

  logic [COUNT_W-1:0] node_count_r;
  logic [NODE_W-1:0]  clique_size_r;
  logic               wr_fire;
  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] c_hi;
  logic [COUNT_W-1:0] c_ext;

  assign wr_fire = psel && penable && pwrite;

  // Register writes; the address bit above the word offset picks the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NODE_COUNT_RST;
      clique_size_r <= CLIQUE_SIZE_RST;
    end else if (wr_fire) begin
      if (paddr[2] == REG_NODE_COUNT) begin
        node_count_r <= pwdata[COUNT_W-1:0];
      end else begin
        clique_size_r <= pwdata[NODE_W-1:0];
      end
    end
  end

  // Read back the raw register values.
  always_comb begin
    if (paddr[2] == REG_CLIQUE_SIZE) begin
      prdata = CFG_DW'(clique_size_r);
    end else begin
      prdata = CFG_DW'(node_count_r);
    end
  end

  // Clamp node count to [2, MAXC] and clique size to [1, nodes-1].
  always_comb begin
    if (node_count_r < NODES_LO) begin
      n_eff = NODES_LO;
    end else if (node_count_r > NODES_HI) begin
      n_eff = NODES_HI;
    end else begin
      n_eff = node_count_r;
    end
    c_hi  = n_eff - COUNT_W'(1);
    c_ext = COUNT_W'(clique_size_r);
    if (c_ext == '0) begin
      c_ext = COUNT_W'(1);
    end else if (c_ext > c_hi) begin
      c_ext = c_hi;
    end
    graph.nodes  = n_eff;
    graph.clique = c_ext[NODE_W-1:0];
  end

endmodule

// ===== design/lrw_visit_ram.sv =====
// Visited-map memory of the lollipop random-walk cover block.
// One write and one registered read per cycle, with read-during-write forwarding.
// Depends on lrw_pkg.
module lrw_visit_ram import lrw_pkg::*; #(
  parameter int DEPTH = MAX_NODES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [EPOCH_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [EPOCH_W-1:0] rd_data
);

  logic [EPOCH_W-1:0] mem [DEPTH];
  logic [EPOCH_W-1:0] q_r;
  logic [EPOCH_W-1:0] fwd_data_r;
  logic               fwd_r;

  // Storage array: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // A read that collides with a write in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

// ===== design/lrw_outq.sv =====
// Result queue of the lollipop random-walk cover block.
// A small register FIFO that decouples the walk pipeline from out_ready.
// Depends on lrw_pkg.
module lrw_outq import lrw_pkg::*; #(
  parameter int DEPTH = OUTQ_DEPTH,
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  output logic [CW-1:0] count
);

  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  out_item_t       slots [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = slots[rd_ptr_r];
  assign count     = count_r;

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== design/lollipop_random_walk_cover.sv =====
// Top level of the lollipop random-walk cover block.
// Walk pipeline around the visited-map memory; uses lrw_cfg, lrw_visit_ram, lrw_outq.
// Depends on lrw_pkg.
//
// The block takes one transaction per clock cycle while in_ready is high and returns its
// result from the update-stage registers through a three-entry result queue. The walker
// position and step count update in the accept cycle; the visited map is read then and
// written back in the following cycle, with forwarding when consecutive steps hit the same
// node. When a step in flight could be the one that completes cover (visited count one
// below the node count), the next transaction waits for it. The visited map keeps a walk
// epoch per node, so a start costs no clearing time, except that after reset and on every
// 255th start the map is swept clear, one node per cycle, while no transaction is accepted.
module lollipop_random_walk_cover import lrw_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // Result channel.
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // Configuration port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int XW = (AW > COUNT_W) ? AW : COUNT_W;
  localparam int QW = $clog2(OUTQ_DEPTH + 1);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_NODES - 1);

  graph_t graph;

  // Accept-stage state.
  logic [AW-1:0]      walker_r;
  logic [STEP_W-1:0]  steps_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [COUNT_W-1:0] total_r;

  // Clearing sweep state.
  logic               sweep_r;
  logic [AW-1:0]      sweep_idx_r;
  logic               sweep_mark0_r;

  // Update-stage registers.
  logic               b_valid_r;
  logic               b_start_r;
  logic               b_take_r;
  logic               b_wrap_r;
  logic [AW-1:0]      b_node_r;
  logic [EPOCH_W-1:0] b_epoch_r;
  logic [STEP_W-1:0]  b_steps_r;

  // Accept-stage decode.
  logic               in_fire;
  logic               stall;
  logic               finished;
  logic               take;
  logic               is_start;
  logic               wrap;
  logic [XW-1:0]      w_x;
  logic [XW-1:0]      c_x;
  logic [XW-1:0]      n_x;
  logic [XW-1:0]      cand_x;
  logic [XW-1:0]      next_x;
  logic [AW-1:0]      step_dst;
  logic [STEP_W-1:0]  steps_inc;
  logic [COUNT_W-1:0] total_ahead;
  logic [COUNT_W:0]   total_plus;

  // Memory ports.
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [EPOCH_W-1:0] wr_data;
  logic [EPOCH_W-1:0] rd_data;

  // Update-stage results.
  logic               seen;
  logic [COUNT_W-1:0] total_nxt;
  out_item_t          res;
  logic [QW-1:0]      q_count;
  logic [QW:0]        occupancy;

  lrw_cfg #(
    .MAX_NODES (MAX_NODES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .graph   (graph)
  );

  assign cfg_pready = 1'b1;

  // Flow control: room in the result path, no sweep, no unresolved cover.
  assign total_plus = {1'b0, total_r} + (COUNT_W + 1)'(1);
  assign stall      = b_valid_r && !b_start_r && b_take_r
                      && (total_plus >= (COUNT_W + 1)'(graph.nodes));
  assign occupancy  = (QW + 1)'(q_count) + (QW + 1)'(b_valid_r);
  assign in_ready   = !sweep_r && !stall && (occupancy < (QW + 1)'(OUTQ_DEPTH));
  assign in_fire    = in_valid && in_ready;

  // Visited count as it stands once the item in the update stage retires.
  assign total_ahead = (b_valid_r && b_start_r) ? COUNT_W'(1) : total_r;
  assign finished    = (total_ahead >= graph.nodes);
  assign is_start    = (in_data.operation == OP_START);
  assign wrap        = (epoch_r == EPOCH_LAST);

  // Move decision for clique, junction and path positions.
  always_comb begin
    w_x    = XW'(walker_r);
    c_x    = XW'(graph.clique);
    n_x    = XW'(graph.nodes);
    cand_x = XW'(in_data.candidate_node);
    next_x = w_x;
    take   = 1'b0;
    if (w_x < c_x - XW'(1)) begin
      take   = (cand_x < c_x) && (cand_x != w_x);
      next_x = cand_x;
    end else if (w_x == c_x - XW'(1)) begin
      take   = (cand_x <= c_x) && (cand_x != w_x);
      next_x = cand_x;
    end else begin
      take = 1'b1;
      if ((w_x >= n_x - XW'(1)) || (in_data.direction == DIR_DOWN)) begin
        next_x = w_x - XW'(1);
      end else begin
        next_x = w_x + XW'(1);
      end
    end
    take     = take && !is_start && !finished;
    step_dst = next_x[AW-1:0];
  end

  assign steps_inc = (steps_r == STEP_MAX) ? steps_r : steps_r + STEP_W'(1);

  // Walker, step counter and epoch advance in the accept cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walker_r <= '0;
      steps_r  <= '0;
      epoch_r  <= EPOCH_FIRST;
    end else if (in_fire) begin
      if (is_start) begin
        walker_r <= '0;
        steps_r  <= '0;
        epoch_r  <= wrap ? EPOCH_FIRST : epoch_r + EPOCH_W'(1);
      end else if (take) begin
        walker_r <= step_dst;
        steps_r  <= steps_inc;
      end
    end
  end

  // Clearing sweep after reset and when the epoch wraps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r       <= 1'b1;
      sweep_idx_r   <= '0;
      sweep_mark0_r <= 1'b0;
    end else if (in_fire && is_start && wrap) begin
      sweep_r       <= 1'b1;
      sweep_idx_r   <= '0;
      sweep_mark0_r <= 1'b1;
    end else if (sweep_r) begin
      sweep_idx_r <= sweep_idx_r + AW'(1);
      if (sweep_idx_r == SWEEP_LAST) begin
        sweep_r <= 1'b0;
      end
    end
  end

  // Update-stage pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_start_r <= is_start;
      b_take_r  <= take;
      b_wrap_r  <= wrap;
      b_node_r  <= is_start ? '0 : (take ? step_dst : walker_r);
      b_epoch_r <= is_start ? (wrap ? EPOCH_FIRST : epoch_r + EPOCH_W'(1)) : epoch_r;
      b_steps_r <= is_start ? '0 : (take ? steps_inc : steps_r);
    end
  end

  // Write port: the sweep has priority, then the mark of the update stage.
  always_comb begin
    if (sweep_r) begin
      wr_en   = 1'b1;
      wr_addr = sweep_idx_r;
      wr_data = (sweep_mark0_r && (sweep_idx_r == '0)) ? epoch_r : EPOCH_NONE;
    end else begin
      wr_en   = b_valid_r && (b_take_r || (b_start_r && !b_wrap_r));
      wr_addr = b_node_r;
      wr_data = b_epoch_r;
    end
  end

  lrw_visit_ram #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (step_dst),
    .rd_data (rd_data)
  );

  // Visited count update and result assembly.
  assign seen = (rd_data == b_epoch_r);

  always_comb begin
    if (b_start_r) begin
      total_nxt = COUNT_W'(1);
    end else if (b_take_r && !seen) begin
      total_nxt = total_r + COUNT_W'(1);
    end else begin
      total_nxt = total_r;
    end
    res.accepted      = b_take_r;
    res.node          = NODE_W'(b_node_r);
    res.visited_count = total_nxt;
    res.step_count    = b_steps_r;
    res.covered       = (total_nxt >= graph.nodes);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (b_valid_r) begin
      total_r <= total_nxt;
    end
  end

  lrw_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_valid_r),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

  // The update stage never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (q_count < QW'(OUTQ_DEPTH)))
    else $error("result queue overflow");

  // A taken step only starts from a walk that is not yet covered.
  a_take_uncovered: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_take_r) |-> (total_r < graph.nodes))
    else $error("step taken on a covered walk");

  // A taken step always leaves a nonzero step count.
  a_step_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.accepted) |-> (out_data.step_count != '0))
    else $error("accepted step with zero step count");

  // No transaction enters while the map is being swept.
  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r |=> (!b_valid_r || $past(b_valid_r) == 1'b0 || b_start_r || !sweep_r))
    else $error("transaction accepted during map sweep");

endmodule
